/* hw/rtl/matinv_pkg.sv */
// shared constants and flag types for the 3x3 matrix inverse core
package matinv_pkg;

   // default element format, signed q16.16
   localparam int ELEM_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // elements per matrix
   localparam int NUM_ELEMS = 9;

   // pipeline stages ahead of the divider lanes
   localparam int PRE_STAGES = 5;

   // per-lane status that travels from a divider lane to the merge stage
   typedef struct packed {
      logic ovf;
      logic neg;
   } lane_flags_type;

   // determinant status handed to the merge stage
   typedef struct packed {
      logic sat;
      logic singular;
   } det_flags_type;

endpackage

/* hw/rtl/matinv_cofactor.sv */
// cofactor stages: eighteen signed products, then nine cofactors
module matinv_cofactor #(
   parameter int ELEM_WIDTH = matinv_pkg::ELEM_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic [1:0]                    stage_en,
   input  logic signed [ELEM_WIDTH-1:0]  m [matinv_pkg::NUM_ELEMS],
   output logic signed [2*ELEM_WIDTH:0]  cof [matinv_pkg::NUM_ELEMS],
   output logic signed [ELEM_WIDTH-1:0]  row [3]
);

   localparam int PW = 2 * ELEM_WIDTH;

   logic signed [PW-1:0]          p_ff   [matinv_pkg::NUM_ELEMS];
   logic signed [PW-1:0]          q_ff   [matinv_pkg::NUM_ELEMS];
   logic signed [PW:0]            cof_ff [matinv_pkg::NUM_ELEMS];
   logic signed [ELEM_WIDTH-1:0]  row0_ff [3];
   logic signed [ELEM_WIDTH-1:0]  row1_ff [3];

   genvar gi, gj;
   generate
      for (gi = 0; gi < 3; gi++) begin : g_row
         for (gj = 0; gj < 3; gj++) begin : g_col
            localparam int K  = 3 * gi + gj;
            localparam int PA = ((gi + 1) % 3) * 3 + (gj + 1) % 3;
            localparam int PB = ((gi + 2) % 3) * 3 + (gj + 2) % 3;
            localparam int QA = ((gi + 1) % 3) * 3 + (gj + 2) % 3;
            localparam int QB = ((gi + 2) % 3) * 3 + (gj + 1) % 3;

            always_ff @(posedge clock) begin
               if (stage_en[0]) begin
                  p_ff[K] <= m[PA] * m[PB];
                  q_ff[K] <= m[QA] * m[QB];
               end
               if (stage_en[1]) begin
                  cof_ff[K] <= (PW+1)'(p_ff[K]) - (PW+1)'(q_ff[K]);
               end
            end

            assign cof[K] = cof_ff[K];
         end

         // first row rides along for the determinant expansion
         always_ff @(posedge clock) begin
            if (stage_en[0]) begin
               row0_ff[gi] <= m[gi];
            end
            if (stage_en[1]) begin
               row1_ff[gi] <= row0_ff[gi];
            end
         end

         assign row[gi] = row1_ff[gi];
      end
   endgenerate

endmodule

/* hw/rtl/matinv_det.sv */
// determinant stages: first-row expansion with split partial products
module matinv_det #(
   parameter int ELEM_WIDTH = matinv_pkg::ELEM_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic [2:0]                     stage_en,
   input  logic signed [2*ELEM_WIDTH:0]   cof_i [matinv_pkg::NUM_ELEMS],
   input  logic signed [ELEM_WIDTH-1:0]   row [3],
   output logic signed [2*ELEM_WIDTH:0]   cof_o [matinv_pkg::NUM_ELEMS],
   output logic signed [3*ELEM_WIDTH+2:0] det
);

   localparam int W  = ELEM_WIDTH;
   localparam int CW = 2 * W + 1;
   localparam int HW = 2 * W + 1;
   localparam int DW = 3 * W + 3;

   logic signed [HW-1:0] ph_ff   [3];
   logic signed [HW-1:0] pl_ff   [3];
   logic signed [DW-1:0] term_ff [3];
   logic signed [DW-1:0] det_ff;
   logic signed [CW-1:0] c2_ff [matinv_pkg::NUM_ELEMS];
   logic signed [CW-1:0] c3_ff [matinv_pkg::NUM_ELEMS];
   logic signed [CW-1:0] c4_ff [matinv_pkg::NUM_ELEMS];

   genvar gj, gk;
   generate
      for (gj = 0; gj < 3; gj++) begin : g_term
         logic signed [DW-1:0] ph_x;
         logic signed [DW-1:0] pl_x;

         assign ph_x = DW'(ph_ff[gj]);
         assign pl_x = DW'(pl_ff[gj]);

         always_ff @(posedge clock) begin
            if (stage_en[0]) begin
               // high part signed, low part unsigned
               ph_ff[gj] <= row[gj] * $signed(cof_i[gj][CW-1:W]);
               pl_ff[gj] <= row[gj] * $signed({1'b0, cof_i[gj][W-1:0]});
            end
            if (stage_en[1]) begin
               term_ff[gj] <= (ph_x <<< W) + pl_x;
            end
         end
      end

      for (gk = 0; gk < matinv_pkg::NUM_ELEMS; gk++) begin : g_carry
         always_ff @(posedge clock) begin
            if (stage_en[0]) begin
               c2_ff[gk] <= cof_i[gk];
            end
            if (stage_en[1]) begin
               c3_ff[gk] <= c2_ff[gk];
            end
            if (stage_en[2]) begin
               c4_ff[gk] <= c3_ff[gk];
            end
         end

         assign cof_o[gk] = c4_ff[gk];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         det_ff <= term_ff[0] + term_ff[1] + term_ff[2];
      end
   end

   assign det = det_ff;

endmodule

/* hw/rtl/matinv_div_lane.sv */
// one divider lane: magnitudes, overflow test, one quotient bit per stage
module matinv_div_lane #(
   parameter int ELEM_WIDTH = matinv_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = matinv_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic [ELEM_WIDTH+1:0]           stage_en,
   input  logic signed [2*ELEM_WIDTH:0]    cof,
   input  logic signed [3*ELEM_WIDTH+2:0]  det,
   output logic [ELEM_WIDTH-1:0]           quo,
   output matinv_pkg::lane_flags_type      flags
);

   localparam int W   = ELEM_WIDTH;
   localparam int CW  = 2 * W + 1;
   localparam int DW  = 3 * W + 3;
   localparam int NW  = CW + 2 * FRAC_BITS;
   localparam int RW0 = (NW > DW + W) ? NW : DW + W;
   localparam int RW  = RW0 + 1;

   logic [CW-1:0] cof_mag_in;
   logic [DW-1:0] det_mag_in;

   logic [NW-1:0] na_ff;
   logic [DW-1:0] da_ff;
   logic          nega_ff;

   logic [RW-1:0] rem_ff [W+1];
   logic [DW-1:0] d_ff   [W+1];
   logic [W-1:0]  q_ff   [W+1];
   logic          ovf_ff [W+1];
   logic          neg_ff [W+1];

   assign cof_mag_in = cof[CW-1] ? (~cof + 1'b1) : cof;
   assign det_mag_in = det[DW-1] ? (~det + 1'b1) : det;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         na_ff   <= NW'(cof_mag_in) << (2 * FRAC_BITS);
         da_ff   <= det_mag_in;
         nega_ff <= cof[CW-1] ^ det[DW-1];
      end
      if (stage_en[1]) begin
         rem_ff[0] <= RW'(na_ff);
         d_ff[0]   <= da_ff;
         q_ff[0]   <= '0;
         ovf_ff[0] <= RW'(na_ff) >= (RW'(da_ff) << W);
         neg_ff[0] <= nega_ff;
      end
   end

   genvar gs;
   generate
      for (gs = 1; gs <= W; gs++) begin : g_step
         localparam int BIT = W - gs;
         logic [RW:0] trial;

         assign trial = {1'b0, rem_ff[gs-1]} - ((RW+1)'(d_ff[gs-1]) << BIT);

         always_ff @(posedge clock) begin
            if (stage_en[gs+1]) begin
               rem_ff[gs] <= trial[RW] ? rem_ff[gs-1] : trial[RW-1:0];
               q_ff[gs]   <= q_ff[gs-1] | (W'(!trial[RW]) << BIT);
               d_ff[gs]   <= d_ff[gs-1];
               ovf_ff[gs] <= ovf_ff[gs-1];
               neg_ff[gs] <= neg_ff[gs-1];
            end
         end
      end
   endgenerate

   assign quo       = q_ff[W];
   assign flags.ovf = ovf_ff[W];
   assign flags.neg = neg_ff[W];

endmodule

/* hw/rtl/matinv_merge.sv */
// merge stage: saturate the nine lanes, zero on singular, gather flags
module matinv_merge #(
   parameter int ELEM_WIDTH = matinv_pkg::ELEM_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           stage_en,
   input  logic [ELEM_WIDTH-1:0]          quo [matinv_pkg::NUM_ELEMS],
   input  matinv_pkg::lane_flags_type     flags [matinv_pkg::NUM_ELEMS],
   input  logic signed [ELEM_WIDTH-1:0]   det_value,
   input  matinv_pkg::det_flags_type      det_flags,
   output logic signed [ELEM_WIDTH-1:0]   r [matinv_pkg::NUM_ELEMS],
   output logic signed [ELEM_WIDTH-1:0]   determinant,
   output logic                           singular,
   output logic                           saturated
);

   localparam int W = ELEM_WIDTH;
   localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

   logic [matinv_pkg::NUM_ELEMS-1:0] clip;
   logic signed [W-1:0]              val [matinv_pkg::NUM_ELEMS];
   logic signed [W-1:0]              r_ff [matinv_pkg::NUM_ELEMS];
   logic signed [W-1:0]              det_ff;
   logic                             sing_ff;
   logic                             sat_ff;

   genvar gk;
   generate
      for (gk = 0; gk < matinv_pkg::NUM_ELEMS; gk++) begin : g_lane
         logic [W-1:0] lim;
         logic [W-1:0] mag;

         assign lim      = flags[gk].neg ? LIM_NEG : LIM_POS;
         assign clip[gk] = flags[gk].ovf || (quo[gk] > lim);
         assign mag      = clip[gk] ? lim : quo[gk];
         assign val[gk]  = flags[gk].neg ? (~mag + 1'b1) : mag;

         always_ff @(posedge clock) begin
            if (stage_en) begin
               r_ff[gk] <= det_flags.singular ? '0 : val[gk];
            end
         end

         assign r[gk] = r_ff[gk];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (stage_en) begin
         det_ff  <= det_flags.singular ? '0 : det_value;
         sing_ff <= det_flags.singular;
         sat_ff  <= !det_flags.singular && ((|clip) || det_flags.sat);
      end
   end

   assign determinant = det_ff;
   assign singular    = sing_ff;
   assign saturated   = sat_ff;

endmodule

/* hw/rtl/matrix3x3_inverse_core.sv */
// top level of the 3x3 matrix inverse core (adjugate over determinant)
//
// usage
//   req_ channel carries one 3x3 matrix of signed fixed-point elements per
//   transaction (req_m11 .. req_m33, row-major); rsp_ channel returns the
//   inverse (rsp_r11 .. rsp_r33), the determinant and the singular and
//   saturated flags. both channels are valid/ready.
//   the pipeline runs through two cofactor stages, three determinant
//   stages, nine divider lanes of ELEM_WIDTH + 2 stages each (magnitudes,
//   overflow test, then one quotient bit per stage; determinant format
//   runs beside the first lane stage) and a merge register.
//   throughput is one transaction per cycle unless every stage is full
//   and rsp_ready is low; the bit-serial divider lanes are fully
//   pipelined, so their depth does not limit the throughput.
//   each stage holds a valid bit and advances whenever it or any stage
//   after it is empty, so bubbles close up while rsp_ready is low and
//   req_ready drops only when every stage holds a transaction.
//   a singular matrix returns all-zero elements and determinant, singular
//   high and saturated low. values beyond the element range clip.
//   reset is synchronous and clears the valid bits only; the pipeline is
//   empty and rsp_valid low after reset, no clearing pass is needed
module matrix3x3_inverse_core #(
   parameter int ELEM_WIDTH = matinv_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = matinv_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [ELEM_WIDTH-1:0]  req_m11,
   input  logic signed [ELEM_WIDTH-1:0]  req_m12,
   input  logic signed [ELEM_WIDTH-1:0]  req_m13,
   input  logic signed [ELEM_WIDTH-1:0]  req_m21,
   input  logic signed [ELEM_WIDTH-1:0]  req_m22,
   input  logic signed [ELEM_WIDTH-1:0]  req_m23,
   input  logic signed [ELEM_WIDTH-1:0]  req_m31,
   input  logic signed [ELEM_WIDTH-1:0]  req_m32,
   input  logic signed [ELEM_WIDTH-1:0]  req_m33,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [ELEM_WIDTH-1:0]  rsp_r11,
   output logic signed [ELEM_WIDTH-1:0]  rsp_r12,
   output logic signed [ELEM_WIDTH-1:0]  rsp_r13,
   output logic signed [ELEM_WIDTH-1:0]  rsp_r21,
   output logic signed [ELEM_WIDTH-1:0]  rsp_r22,
   output logic signed [ELEM_WIDTH-1:0]  rsp_r23,
   output logic signed [ELEM_WIDTH-1:0]  rsp_r31,
   output logic signed [ELEM_WIDTH-1:0]  rsp_r32,
   output logic signed [ELEM_WIDTH-1:0]  rsp_r33,
   output logic signed [ELEM_WIDTH-1:0]  rsp_determinant,
   output logic                          rsp_singular,
   output logic                          rsp_saturated
);

   localparam int W   = ELEM_WIDTH;
   localparam int CW  = 2 * W + 1;
   localparam int DW  = 3 * W + 3;
   localparam int NS  = W + 8;                // total pipeline stages
   localparam int LS  = matinv_pkg::PRE_STAGES;
   localparam int DM  = DW - 2 * FRAC_BITS;   // determinant magnitude after scaling
   localparam int XW  = (DM > W) ? DM : W;
   localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

   // stage valid bits and advance enables
   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_in;
   logic [NS-1:0] en;

   genvar gs;
   generate
      for (gs = 0; gs < NS; gs++) begin : g_en
         // a stage holds only when it and everything after it is full
         assign en[gs] = !(&v_ff[NS-1:gs]) || rsp_ready;
      end
   endgenerate

   assign v_in = (en & {v_ff[NS-2:0], req_valid}) | (~en & v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[NS-1];

   // matrix in row-major order
   logic signed [W-1:0] m_in [matinv_pkg::NUM_ELEMS];

   assign m_in[0] = req_m11;
   assign m_in[1] = req_m12;
   assign m_in[2] = req_m13;
   assign m_in[3] = req_m21;
   assign m_in[4] = req_m22;
   assign m_in[5] = req_m23;
   assign m_in[6] = req_m31;
   assign m_in[7] = req_m32;
   assign m_in[8] = req_m33;

   // cofactors
   logic signed [CW-1:0] cof_s1 [matinv_pkg::NUM_ELEMS];
   logic signed [W-1:0]  row_s1 [3];

   matinv_cofactor #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_cofactor (
      .clock    (clock),
      .stage_en (en[1:0]),
      .m        (m_in),
      .cof      (cof_s1),
      .row      (row_s1)
   );

   // determinant
   logic signed [CW-1:0] cof_s4 [matinv_pkg::NUM_ELEMS];
   logic signed [DW-1:0] det_s4;

   matinv_det #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_det (
      .clock    (clock),
      .stage_en (en[4:2]),
      .cof_i    (cof_s1),
      .row      (row_s1),
      .cof_o    (cof_s4),
      .det      (det_s4)
   );

   // nine divider lanes; element (i,j) divides cofactor (j,i)
   logic [W-1:0]               quo   [matinv_pkg::NUM_ELEMS];
   matinv_pkg::lane_flags_type lflag [matinv_pkg::NUM_ELEMS];

   genvar gi, gj;
   generate
      for (gi = 0; gi < 3; gi++) begin : g_lrow
         for (gj = 0; gj < 3; gj++) begin : g_lcol
            matinv_div_lane #(
               .ELEM_WIDTH (ELEM_WIDTH),
               .FRAC_BITS  (FRAC_BITS)
            ) u_lane (
               .clock    (clock),
               .stage_en (en[LS+W+1:LS]),
               .cof      (cof_s4[3*gj+gi]),
               .det      (det_s4),
               .quo      (quo[3*gi+gj]),
               .flags    (lflag[3*gi+gj])
            );
         end
      end
   endgenerate

   // determinant output format: truncate toward zero, then clip
   logic [DW-1:0] det_mag_in;
   logic [DM-1:0] dmag_ff;
   logic          dneg_ff;
   logic          dsing_ff;
   logic [W-1:0]  dlim;
   logic          dclip;
   logic [W-1:0]  dsel;
   logic signed [W-1:0] dval_in;

   assign det_mag_in = det_s4[DW-1] ? (~det_s4 + 1'b1) : det_s4;

   always_ff @(posedge clock) begin
      if (en[LS]) begin
         dmag_ff  <= DM'(det_mag_in >> (2 * FRAC_BITS));
         dneg_ff  <= det_s4[DW-1];
         dsing_ff <= (det_s4 == '0);
      end
   end

   assign dlim    = dneg_ff ? LIM_NEG : LIM_POS;
   assign dclip   = XW'(dmag_ff) > XW'(dlim);
   assign dsel    = dclip ? dlim : W'(dmag_ff);
   assign dval_in = dneg_ff ? (~dsel + 1'b1) : dsel;

   // determinant value and flags ride alongside the divider lanes
   logic signed [W-1:0]       dval_ff [W+1];
   matinv_pkg::det_flags_type dflg_ff [W+1];

   always_ff @(posedge clock) begin
      if (en[LS+1]) begin
         dval_ff[0]          <= dval_in;
         dflg_ff[0].sat      <= dclip;
         dflg_ff[0].singular <= dsing_ff;
      end
   end

   generate
      for (gs = 1; gs <= W; gs++) begin : g_dline
         always_ff @(posedge clock) begin
            if (en[LS+1+gs]) begin
               dval_ff[gs] <= dval_ff[gs-1];
               dflg_ff[gs] <= dflg_ff[gs-1];
            end
         end
      end
   endgenerate

   // merge and output register
   logic signed [W-1:0] r_out [matinv_pkg::NUM_ELEMS];

   matinv_merge #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_merge (
      .clock       (clock),
      .stage_en    (en[NS-1]),
      .quo         (quo),
      .flags       (lflag),
      .det_value   (dval_ff[W]),
      .det_flags   (dflg_ff[W]),
      .r           (r_out),
      .determinant (rsp_determinant),
      .singular    (rsp_singular),
      .saturated   (rsp_saturated)
   );

   assign rsp_r11 = r_out[0];
   assign rsp_r12 = r_out[1];
   assign rsp_r13 = r_out[2];
   assign rsp_r21 = r_out[3];
   assign rsp_r22 = r_out[4];
   assign rsp_r23 = r_out[5];
   assign rsp_r31 = r_out[6];
   assign rsp_r32 = r_out[7];
   assign rsp_r33 = r_out[8];

   // a singular response carries a zero determinant, zero r11, r22, r33 and r13, and no clip flag
   a_singular_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |-> (!rsp_saturated && rsp_determinant == '0
         && rsp_r11 == '0 && rsp_r22 == '0 && rsp_r33 == '0 && rsp_r13 == '0))
      else $error("singular response not cleared");

   // input stalls only when every stage is occupied
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&v_ff))
      else $error("request stalled with a bubble in the pipeline");

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (v_ff == '0))
      else $error("pipeline not empty after reset");

endmodule
